/* sv/lzr_pkg.sv */
`default_nettype none

package lzr_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_LIT  = 2'd1;
  localparam logic [1:0] OP_COPY = 2'd2;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_LITERAL = 2'd1;
  localparam logic [1:0] PH_OFFSET  = 2'd2;

  localparam logic [7:0] HDR_MATCH_MIN = 8'h80;
  localparam logic [4:0] MIN_MATCH     = 5'd3;
  localparam int unsigned MAX_DIST     = 2048;
  localparam int unsigned DIST_W       = $clog2(MAX_DIST) + 1;

  typedef struct packed {
    logic              clear;
    logic [1:0]        op;
    logic [7:0]        data;
    logic [DIST_W-1:0] reach;
    logic [4:0]        len;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic busy;
  } bk_stat_t;

endpackage

`default_nettype wire

/* sv/lz_ring_decompressor.sv */
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall   | in_data  : in_byte, new_stream
// out     | output    | out_valid/out_stall | out_data : out_byte, run_last
//
// A header beat sets the front's phase registers; an offset or literal beat
// pushes a command; a literal's byte is then registered into the output queue.
// A copy streams at one byte a cycle while the output queue has room.
// Reset clears control state only; the history is tracked by a fill pointer.
// Either side may stall: a two-entry command queue and a four-beat output queue
// decouple them.
`default_nettype none

module lz_ring_decompressor #(
  parameter int unsigned HISTORY_DEPTH = 2048
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire lzr_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output lzr_pkg::out_item_t      out_data
);

  import lzr_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);

  q_stat_t       q_stat;
  bk_stat_t      bk_stat;
  cmd_t          push_cmd, head_cmd;
  logic          q_push, q_pop;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  lzr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  lzr_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head_cmd),
    .stat     (q_stat)
  );

  lzr_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (head_cmd),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .stat      (bk_stat),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  lzr_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("queues not empty after reset");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !bk_stat.busy)
    else $error("command taken while a copy is running");

  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty && !bk_stat.busy && !out_valid |=> !out_valid)
    else $error("output beat with no work pending");
`endif

endmodule

`default_nettype wire

/* sv/lzr_ram.sv */
`default_nettype none

module lzr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/lzr_front.sv */
`default_nettype none

module lzr_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire lzr_pkg::in_item_t in_data,
  input  wire lzr_pkg::q_stat_t  q_stat,
  output logic                 q_push,
  output lzr_pkg::cmd_t        q_cmd
);

  import lzr_pkg::*;

  logic [1:0] phase_r, phase_nxt;
  logic [6:0] lit_left_r, lit_left_nxt;
  logic [3:0] mlen_r, mlen_nxt;
  logic [2:0] ohigh_r, ohigh_nxt;
  logic [1:0] phase_eff;
  logic       accept;

  assign in_stall  = q_stat.full;
  assign accept    = in_valid && !q_stat.full;
  assign phase_eff = in_data.new_stream ? PH_HEADER : phase_r;

  always_comb begin
    phase_nxt    = phase_r;
    lit_left_nxt = in_data.new_stream ? 7'd0 : lit_left_r;
    mlen_nxt     = in_data.new_stream ? 4'd0 : mlen_r;
    ohigh_nxt    = in_data.new_stream ? 3'd0 : ohigh_r;
    q_cmd.clear  = in_data.new_stream;
    q_cmd.op     = OP_NONE;
    q_cmd.data   = in_data.in_byte;
    q_cmd.reach  = DIST_W'(in_data.in_byte) + DIST_W'(1) + {1'b0, ohigh_r, 8'h00};
    q_cmd.len    = 5'(mlen_r) + MIN_MATCH;
    unique case (phase_eff)
      PH_LITERAL: begin
        q_cmd.op = OP_LIT;
        if (lit_left_r == 7'd0) begin
          phase_nxt = PH_HEADER;
        end else begin
          lit_left_nxt = lit_left_r - 7'd1;
        end
      end
      PH_OFFSET: begin
        q_cmd.op  = OP_COPY;
        phase_nxt = PH_HEADER;
      end
      default: begin
        if (in_data.in_byte < HDR_MATCH_MIN) begin
          lit_left_nxt = in_data.in_byte[6:0];
          phase_nxt    = PH_LITERAL;
        end else begin
          mlen_nxt  = in_data.in_byte[3:0];
          ohigh_nxt = in_data.in_byte[6:4];
          phase_nxt = PH_OFFSET;
        end
      end
    endcase
  end

  assign q_push = accept && (in_data.new_stream || (q_cmd.op != OP_NONE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      lit_left_r <= 7'd0;
      mlen_r     <= 4'd0;
      ohigh_r    <= 3'd0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      lit_left_r <= lit_left_nxt;
      mlen_r     <= mlen_nxt;
      ohigh_r    <= ohigh_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/lzr_cmd_queue.sv */
`default_nettype none

module lzr_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire lzr_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output lzr_pkg::cmd_t      head,
  output lzr_pkg::q_stat_t   stat
);

  import lzr_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign head       = slot_r[rd_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= !wr_r;
      end
      if (pop) begin
        rd_r <= !rd_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

/* sv/lzr_back.sv */
`default_nettype none

module lzr_back #(
  parameter int unsigned HISTORY_DEPTH = 2048
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire lzr_pkg::cmd_t                    cmd,
  input  wire lzr_pkg::q_stat_t                 q_stat,
  output logic                                  q_pop,
  output lzr_pkg::bk_stat_t                     stat,
  output logic                                  ram_we,
  output logic [$clog2(HISTORY_DEPTH)-1:0]      ram_waddr,
  output logic [7:0]                            ram_wdata,
  output logic [$clog2(HISTORY_DEPTH)-1:0]      ram_raddr,
  input  wire logic [7:0]                       ram_rdata,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output lzr_pkg::out_item_t                    out_data
);

  import lzr_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned PW = AW + 1;
  localparam logic [AW-1:0] RING_END = AW'(HISTORY_DEPTH - 1);
  localparam logic [PW-1:0] DEPTH_W  = PW'(HISTORY_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_COPY = 1'b1;

  logic          state_r, state_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic          wrap_r, wrap_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic          infl_r, infl_nxt;
  logic          zero_r, zero_nxt;
  logic          byp_r, byp_nxt;
  logic          last_r, last_nxt;
  logic [7:0]    byp_dat_r, byp_dat_nxt;

  out_item_t     fifo_r [4];
  logic [1:0]    fwr_r, frd_r;
  logic [2:0]    occ_r;

  logic [7:0]    ret_dat;
  logic          room, start, issue, push, pop;
  logic [AW-1:0] ptr_eff;
  logic          wrap_eff;
  logic [PW-1:0] ptr_ext, dist_ext;
  logic [AW-1:0] pos_start;
  out_item_t     push_item;

  assign ret_dat  = byp_r ? byp_dat_r : (zero_r ? 8'h00 : ram_rdata);
  assign room     = (occ_r + 3'(infl_r)) <= 3'd3;
  assign start    = (state_r == ST_IDLE) && !q_stat.empty && !infl_r && (occ_r != 3'd4);
  assign issue    = (state_r == ST_COPY) && room;
  assign ptr_eff  = cmd.clear ? '0 : ptr_r;
  assign wrap_eff = cmd.clear ? 1'b0 : wrap_r;
  assign ptr_ext  = {1'b0, ptr_eff};
  assign dist_ext = PW'(cmd.reach);
  assign pos_start = (ptr_ext >= dist_ext) ? AW'(ptr_ext - dist_ext)
                                           : AW'(ptr_ext + DEPTH_W - dist_ext);

  assign q_pop     = start;
  assign stat.busy = (state_r == ST_COPY) || infl_r;

  assign ram_we    = infl_r || (start && (cmd.op == OP_LIT));
  assign ram_waddr = infl_r ? ptr_r : ptr_eff;
  assign ram_wdata = infl_r ? ret_dat : cmd.data;
  assign ram_raddr = pos_r;

  assign push      = ram_we;
  assign push_item = infl_r ? out_item_t'{out_byte: ret_dat, run_last: last_r}
                            : out_item_t'{out_byte: cmd.data, run_last: 1'b1};

  always_comb begin
    state_nxt   = state_r;
    ptr_nxt     = ptr_r;
    wrap_nxt    = wrap_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    infl_nxt    = issue;
    zero_nxt    = zero_r;
    byp_nxt     = byp_r;
    last_nxt    = last_r;
    byp_dat_nxt = byp_dat_r;
    if (infl_r) begin
      ptr_nxt = (ptr_r == RING_END) ? '0 : ptr_r + AW'(1);
      if (ptr_r == RING_END) begin
        wrap_nxt = 1'b1;
      end
    end
    if (start) begin
      ptr_nxt  = ptr_eff;
      wrap_nxt = wrap_eff;
      if (cmd.op == OP_LIT) begin
        ptr_nxt  = (ptr_eff == RING_END) ? '0 : ptr_eff + AW'(1);
        wrap_nxt = wrap_eff || (ptr_eff == RING_END);
      end else if (cmd.op == OP_COPY) begin
        pos_nxt   = pos_start;
        cnt_nxt   = cmd.len;
        state_nxt = ST_COPY;
      end
    end
    if (issue) begin
      zero_nxt    = !wrap_r && (pos_r >= ptr_r);
      byp_nxt     = infl_r && (pos_r == ptr_r);
      byp_dat_nxt = ret_dat;
      last_nxt    = (cnt_r == 5'd1);
      pos_nxt     = (pos_r == RING_END) ? '0 : pos_r + AW'(1);
      cnt_nxt     = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ptr_r   <= '0;
      wrap_r  <= 1'b0;
      infl_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      wrap_r  <= wrap_nxt;
      infl_r  <= infl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r     <= pos_nxt;
    cnt_r     <= cnt_nxt;
    zero_r    <= zero_nxt;
    byp_r     <= byp_nxt;
    last_r    <= last_nxt;
    byp_dat_r <= byp_dat_nxt;
  end

  // output queue, four beats deep so a copy streams at one byte a cycle while the consumer does not stall
  assign out_valid = (occ_r != 3'd0);
  assign out_data  = fifo_r[frd_r];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[fwr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwr_r <= 2'd0;
      frd_r <= 2'd0;
      occ_r <= 3'd0;
    end else begin
      if (push) begin
        fwr_r <= fwr_r + 2'd1;
      end
      if (pop) begin
        frd_r <= frd_r + 2'd1;
      end
      occ_r <= occ_r + 3'(push) - 3'(pop);
    end
  end

endmodule

`default_nettype wire
